// ===== rtl/core/lr_pkg.sv =====
// lr_pkg: shared types for the line rasterizer
// command and status groups between lr_ctrl and lr_datapath; no dependencies
`timescale 1ns / 1ps

package lr_pkg;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // take a new segment, show its first pixel
    logic step;   // advance one pixel along the major axis
  } lr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;   // shown pixel is the segment end
  } lr_sts_t;

endpackage

// ===== rtl/core/line_rasterizer.sv =====
// line_rasterizer: top level of the bresenham line rasterizer
// joins lr_ctrl and lr_datapath; uses lr_pkg
//
//   channel | signals                                  | dir | one beat
//   --------+------------------------------------------+-----+--------------------------
//   in      | in_valid, in_stall, x_start..y_end       | in  | one segment, two endpoints
//   out     | out_valid, out_stall, pixel_x, pixel_y,  | out | one pixel, last_pixel on
//           | last_pixel                               |     | the segment end
//
// a segment of major span n yields n+1 pixel beats, one per cycle without
// back-pressure, so up to 2**COORD_BITS beats; the pacing is the single
// error/position update in the datapath
// the first pixel is shown the cycle after the segment beat is accepted
// the next segment is accepted in the same cycle that the last pixel leaves
// out_stall freezes the shown pixel and all walk state
// rst is synchronous and returns the sequencer to idle; payload is not cleared
`timescale 1ns / 1ps

module line_rasterizer #(
  parameter int COORD_BITS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last_pixel
);
  import lr_pkg::*;

  lr_cmd_t cmd;
  lr_sts_t sts;

  // sequencer: handshakes and load/step decisions
  lr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // walk registers double as the output pixel register
  lr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk     (clk),
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .cmd     (cmd),
    .sts     (sts),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y)
  );

  assign last_pixel = sts.last;

endmodule

// ===== rtl/core/lr_ctrl.sv =====
// lr_ctrl: sequencer for the line rasterizer
// owns both handshakes and issues load/step commands; uses lr_pkg
`timescale 1ns / 1ps

module lr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output lr_pkg::lr_cmd_t cmd,
  input  lr_pkg::lr_sts_t sts
);
  import lr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic out_take;

  assign out_valid = (state == ST_RUN);
  assign out_take  = out_valid && !out_stall;
  // a new segment may enter while the final pixel beat of the old one leaves
  assign in_stall  = out_valid && !(out_take && sts.last);

  assign cmd.load = in_valid && !in_stall;
  assign cmd.step = out_take && !sts.last;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (out_take && sts.last && !cmd.load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/lr_datapath.sv =====
// lr_datapath: bresenham position and error registers
// setup of spans and directions on load, one pixel per step; uses lr_pkg
`timescale 1ns / 1ps

module lr_datapath #(
  parameter int COORD_BITS = 6
) (
  input  logic                  clk,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  lr_pkg::lr_cmd_t       cmd,
  output lr_pkg::lr_sts_t       sts,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y
);
  import lr_pkg::*;

  localparam int ERR_BITS = COORD_BITS + 3;
  localparam logic [COORD_BITS-1:0] ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

  // payload registers
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [ERR_BITS-1:0]   err_term;
  logic [COORD_BITS-1:0] steps_left;
  logic [COORD_BITS-1:0] span_major;
  logic [COORD_BITS-1:0] span_minor;
  logic                  x_dir_neg;
  logic                  y_dir_neg;
  logic                  x_is_major;

  // setup terms
  logic                  x_neg_in;
  logic                  y_neg_in;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic                  x_major_in;
  logic [COORD_BITS-1:0] maj_in;
  logic [COORD_BITS-1:0] min_in;
  logic [ERR_BITS-1:0]   err_init;

  // step terms
  logic                  minor_step;
  logic [ERR_BITS-1:0]   min2;
  logic [ERR_BITS-1:0]   maj2;
  logic [ERR_BITS-1:0]   err_next;
  logic [COORD_BITS-1:0] x_stepped;
  logic [COORD_BITS-1:0] y_stepped;

  assign x_neg_in   = x_end < x_start;
  assign y_neg_in   = y_end < y_start;
  assign dx         = x_neg_in ? (x_start - x_end) : (x_end - x_start);
  assign dy         = y_neg_in ? (y_start - y_end) : (y_end - y_start);
  assign x_major_in = dx > dy;
  assign maj_in     = x_major_in ? dx : dy;
  assign min_in     = x_major_in ? dy : dx;
  assign err_init   = {2'b00, min_in, 1'b0} - {3'b000, maj_in};

  // error is two's complement; sign bit clear means err >= 0
  assign minor_step = !err_term[ERR_BITS-1];
  assign min2       = {2'b00, span_minor, 1'b0};
  assign maj2       = {2'b00, span_major, 1'b0};
  assign err_next   = minor_step ? (err_term + min2 - maj2) : (err_term + min2);
  assign x_stepped  = x_dir_neg ? (cur_x - ONE) : (cur_x + ONE);
  assign y_stepped  = y_dir_neg ? (cur_y - ONE) : (cur_y + ONE);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x      <= x_start;
      cur_y      <= y_start;
      err_term   <= err_init;
      steps_left <= maj_in;
      span_major <= maj_in;
      span_minor <= min_in;
      x_dir_neg  <= x_neg_in;
      y_dir_neg  <= y_neg_in;
      x_is_major <= x_major_in;
    end else if (cmd.step) begin
      err_term   <= err_next;
      steps_left <= steps_left - ONE;
      if (x_is_major || minor_step) cur_x <= x_stepped;
      if (!x_is_major || minor_step) cur_y <= y_stepped;
    end
  end

  assign sts.last = (steps_left == '0);
  assign pixel_x  = cur_x;
  assign pixel_y  = cur_y;

endmodule
